// File: rtl/lcs_pkg.sv
// Shared types and constants for the line centroid steering block.
package lcs_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_KP_GAIN    = 3'd0;
	localparam logic [2:0] REG_BASE_SPEED = 3'd1;
	localparam logic [2:0] REG_CORNER     = 3'd2;
	localparam logic [2:0] REG_WIDE_COUNT = 3'd3;
	localparam logic [2:0] REG_TURN_LIMIT = 3'd4;

	// Action codes of a result beat.
	localparam logic [2:0] ACT_DRIVE   = 3'd0;
	localparam logic [2:0] ACT_REVERSE = 3'd1;
	localparam logic [2:0] ACT_LEFT    = 3'd2;
	localparam logic [2:0] ACT_RIGHT   = 3'd3;
	localparam logic [2:0] ACT_CAL     = 3'd4;

	// Field widths.
	localparam int ERR_W  = 15;
	localparam int CNT_W  = 9;
	localparam int PIX_W  = 8;
	localparam int DRV_W  = 9;
	localparam int KP_W   = 10;
	localparam int LIM_W  = 14;
	localparam int CFG_W  = 14;

	// Saturation limits of the row accumulators.
	localparam int ERR_MAX = 16383;
	localparam int ERR_MIN = -16384;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Depth of the row summary queue.
	localparam int QUEUE_DEPTH = 2;

	// Register reset values.
	localparam logic [KP_W-1:0]         KP_RESET     = 10'd90;
	localparam logic signed [DRV_W-1:0] BASE_RESET   = -9'sd50;
	localparam logic [CNT_W-1:0]        WIDE_RESET   = 9'd300;
	localparam logic [LIM_W-1:0]        LIMIT_RESET  = 14'd150;

	// Configuration values as seen by the back end.
	typedef struct packed {
		logic [KP_W-1:0]         kp_gain;
		logic signed [DRV_W-1:0] base_speed;
		logic                    corner_mode;
		logic [CNT_W-1:0]        wide_count;
		logic [LIM_W-1:0]        turn_error_limit;
	} lcs_cfg_t;

	// Summary of one finished row, passed from front to back.
	typedef struct packed {
		logic                    cal;
		logic [PIX_W-1:0]        thr;
		logic signed [ERR_W-1:0] err;
		logic [CNT_W-1:0]        cnt;
	} lcs_rec_t;

endpackage

// File: rtl/lcs_front.sv
// Pixel front end: calibration, white pixel classification and row accumulation.
module lcs_front #(
	parameter int ROW_WIDTH     = 320,
	parameter int CENTER_COLUMN = 160
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      beat,
	input  logic [lcs_pkg::PIX_W-1:0] pixel,
	input  logic                      row_end,
	output logic                      push,
	output lcs_pkg::lcs_rec_t         push_rec
);
	import lcs_pkg::*;

	localparam int COL_W  = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
	localparam int CTR_W  = $clog2(CENTER_COLUMN + 1);
	localparam int DIFF_W = ((COL_W > CTR_W) ? COL_W : CTR_W) + 1;
	localparam int SUM_W  = ((DIFF_W > ERR_W) ? DIFF_W : ERR_W) + 1;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_WIDTH - 1);

	logic [PIX_W-1:0]        thr_q;
	logic                    cal_q;
	logic [PIX_W-1:0]        max_q;
	logic [PIX_W-1:0]        min_q;
	logic signed [ERR_W-1:0] err_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [COL_W-1:0]        col_q;

	logic [PIX_W-1:0]        max_n;
	logic [PIX_W-1:0]        min_n;
	logic [PIX_W-1:0]        thr_new;
	logic [PIX_W:0]          mm_sum;
	logic                    white;
	logic signed [DIFF_W-1:0] diff;
	logic signed [SUM_W-1:0]  sum;
	logic signed [ERR_W-1:0] err_n;
	logic [CNT_W-1:0]        cnt_n;

	// Per-pixel updates of the row statistics.
	always_comb begin
		max_n   = (pixel > max_q) ? pixel : max_q;
		min_n   = (pixel < min_q) ? pixel : min_q;
		mm_sum  = {1'b0, max_n} + {1'b0, min_n};
		thr_new = mm_sum[PIX_W:1];
		white   = cal_q && (pixel > thr_q);
		diff    = $signed(DIFF_W'(col_q)) - $signed(DIFF_W'(CENTER_COLUMN));
		sum     = SUM_W'(err_q) + SUM_W'(diff);
		err_n   = err_q;
		cnt_n   = cnt_q;
		if (white) begin
			if (sum > SUM_W'(ERR_MAX)) begin
				err_n = ERR_W'(ERR_MAX);
			end else if (sum < SUM_W'(ERR_MIN)) begin
				err_n = ERR_W'(ERR_MIN);
			end else begin
				err_n = ERR_W'(sum);
			end
			if (cnt_q != CNT_MAX) begin
				cnt_n = cnt_q + 1'b1;
			end
		end
	end

	// Row summary handed to the queue on the last pixel.
	assign push          = beat && row_end;
	assign push_rec.cal  = !cal_q;
	assign push_rec.thr  = cal_q ? thr_q : thr_new;
	assign push_rec.err  = err_n;
	assign push_rec.cnt  = cnt_n;

	// Row accumulators and calibration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			cal_q <= 1'b0;
			max_q <= '0;
			min_q <= '1;
			err_q <= '0;
			cnt_q <= '0;
			col_q <= '0;
		end else if (beat) begin
			if (row_end) begin
				if (!cal_q) begin
					thr_q <= thr_new;
					cal_q <= 1'b1;
				end
				max_q <= '0;
				min_q <= '1;
				err_q <= '0;
				cnt_q <= '0;
				col_q <= '0;
			end else begin
				if (!cal_q) begin
					max_q <= max_n;
					min_q <= min_n;
				end
				err_q <= err_n;
				cnt_q <= cnt_n;
				if (col_q < COL_LAST) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/lcs_queue.sv
// Short queue of row summaries between the front end and the back end.
module lcs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcs_pkg::lcs_rec_t push_rec,
	output logic              full,
	output logic              pop_valid,
	output lcs_pkg::lcs_rec_t pop_rec,
	input  logic              pop
);
	import lcs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	lcs_rec_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_rec   = mem_q[rd_q];

	// Storage for queued summaries.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("row summary pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid) else $error("row summary popped from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count beyond depth");
`endif

endmodule

// File: rtl/lcs_back.sv
// Steering back end: action choice, iterative divide, gain multiply and drive output.
module lcs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lcs_pkg::lcs_cfg_t cfg,
	input  logic              rec_valid,
	input  lcs_pkg::lcs_rec_t rec,
	output logic              rec_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata
);
	import lcs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam int QUO_W  = ERR_W + 1;
	localparam int PROD_W = QUO_W + KP_W + 1;
	localparam int ACC_W  = PROD_W + 1;
	localparam int TR_W   = ACC_W - 8;
	localparam int STEP_W = $clog2(ERR_W);

	logic [2:0]              state_q;
	lcs_rec_t                rec_q;
	logic [2:0]              act_q;
	logic [ERR_W-1:0]        dvd_q;
	logic [CNT_W-1:0]        rem_q;
	logic [ERR_W-1:0]        quo_q;
	logic                    neg_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] lsum_q;
	logic signed [ACC_W-1:0] rsum_q;

	logic                    out_valid_q;
	logic [2:0]              out_act_q;
	logic signed [DRV_W-1:0] out_left_q;
	logic signed [DRV_W-1:0] out_right_q;
	logic [PIX_W-1:0]        out_thr_q;
	logic [CNT_W-1:0]        out_cnt_q;

	logic signed [ERR_W:0]   err_w;
	logic signed [ERR_W:0]   lim_w;
	logic                    wide;
	logic [2:0]              act_pick;
	logic [ERR_W-1:0]        mag;
	logic [CNT_W:0]          trial;
	logic                    fits;
	logic signed [QUO_W-1:0] quo_s;
	logic signed [ACC_W-1:0] base_sh;
	logic                    out_free;
	logic signed [DRV_W-1:0] base_sat;
	logic signed [DRV_W-1:0] left_fin;
	logic signed [DRV_W-1:0] right_fin;

	// Divide by 256 toward zero, then clamp to the drive range.
	function automatic logic signed [DRV_W-1:0] drive_of(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] adj;
		logic signed [TR_W-1:0]  t;
		adj = v[ACC_W-1] ? v + ACC_W'(255) : v;
		t   = TR_W'(adj >>> 8);
		if (t > TR_W'(255)) begin
			return DRV_W'(255);
		end else if (t < TR_W'(-255)) begin
			return DRV_W'(-255);
		end else begin
			return DRV_W'(t);
		end
	endfunction

	// Action choice for an incoming summary.
	always_comb begin
		err_w = (ERR_W+1)'(rec.err);
		lim_w = $signed({2'b00, cfg.turn_error_limit});
		wide  = cfg.corner_mode && (rec.cnt > cfg.wide_count);
		if (rec.cal) begin
			act_pick = ACT_CAL;
		end else if (rec.cnt == '0) begin
			act_pick = ACT_REVERSE;
		end else if (wide && (err_w < -lim_w)) begin
			act_pick = ACT_LEFT;
		end else if (wide && (err_w > lim_w)) begin
			act_pick = ACT_RIGHT;
		end else begin
			act_pick = ACT_DRIVE;
		end
		mag = rec.err[ERR_W-1] ? ERR_W'(~rec.err + 1'b1) : ERR_W'(rec.err);
	end

	// One restoring divide step and the datapath around it.
	always_comb begin
		trial     = {rem_q, dvd_q[ERR_W-1]};
		fits      = (trial >= {1'b0, rec_q.cnt});
		quo_s     = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		base_sh   = ACC_W'(cfg.base_speed) <<< 8;
		base_sat  = (cfg.base_speed < DRV_W'(-255)) ? DRV_W'(-255) : cfg.base_speed;
		out_free  = !out_valid_q || m_tready;
		if (act_q == ACT_DRIVE) begin
			left_fin  = drive_of(lsum_q);
			right_fin = drive_of(rsum_q);
		end else if (act_q == ACT_CAL) begin
			left_fin  = '0;
			right_fin = '0;
		end else begin
			left_fin  = base_sat;
			right_fin = base_sat;
		end
	end

	assign rec_pop = (state_q == ST_IDLE) && rec_valid;

	// Sequencer for one row summary.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rec_valid) begin
						state_q <= (act_pick == ACT_DRIVE) ? ST_DIV : ST_FIN;
						step_q  <= STEP_W'(ERR_W - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_MUL;
					end
					step_q <= step_q - 1'b1;
				end
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (rec_valid) begin
					rec_q <= rec;
					act_q <= act_pick;
					dvd_q <= mag;
					rem_q <= '0;
					quo_q <= '0;
					neg_q <= rec.err[ERR_W-1];
				end
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[ERR_W-2:0], 1'b0};
				quo_q <= {quo_q[ERR_W-2:0], fits};
				rem_q <= fits ? CNT_W'(trial - {1'b0, rec_q.cnt}) : CNT_W'(trial);
			end
			ST_MUL: begin
				prod_q <= PROD_W'(quo_s * $signed({1'b0, cfg.kp_gain}));
			end
			ST_SUM: begin
				lsum_q <= base_sh - ACC_W'(prod_q);
				rsum_q <= base_sh + ACC_W'(prod_q);
			end
			default: begin
			end
		endcase
	end

	// Output register; a finished result waits here while the next row is worked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_act_q   <= act_q;
			out_left_q  <= left_fin;
			out_right_q <= right_fin;
			out_thr_q   <= rec_q.thr;
			out_cnt_q   <= (act_q == ACT_CAL) ? '0 : rec_q.cnt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_cnt_q, out_thr_q, out_right_q, out_left_q, out_act_q};

`ifndef SYNTHESIS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rec_q.cnt != '0)) else $error("divide by zero count");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |=> (state_q == ST_DIV) || (state_q == ST_FIN))
		else $error("summary taken without starting work");
`endif

endmodule

// File: rtl/line_centroid_steering.sv
// Path: a drive result passes the queue hand-off, 15 divide steps, multiply, sum and the
// output register; other actions skip the divide, multiply and sum; output stalls add delay.
// Throughput: one pixel per cycle while the two-entry summary queue has room; the
// back end works one row summary at a time and takes the next only once back in idle.
// Reset: arst_n clears all control state and loads the register defaults; the first
// row after reset calibrates the white threshold.
module line_centroid_steering #(
	parameter int ROW_WIDTH     = 320,
	parameter int CENTER_COLUMN = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // pixel[7:0]
	input  logic        s_tlast,   // row_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // action[2:0], left_drive[11:3], right_drive[20:12],
	                               // threshold_out[28:21], white_seen[37:29]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data
);
	import lcs_pkg::*;

	lcs_cfg_t cfg_q;
	lcs_rec_t push_rec;
	lcs_rec_t pop_rec;
	logic     full;
	logic     push;
	logic     pop_valid;
	logic     pop;
	logic     beat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign beat      = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain          <= KP_RESET;
			cfg_q.base_speed       <= BASE_RESET;
			cfg_q.corner_mode      <= 1'b1;
			cfg_q.wide_count       <= WIDE_RESET;
			cfg_q.turn_error_limit <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KP_GAIN:    cfg_q.kp_gain          <= cfg_data[KP_W-1:0];
				REG_BASE_SPEED: cfg_q.base_speed       <= cfg_data[DRV_W-1:0];
				REG_CORNER:     cfg_q.corner_mode      <= cfg_data[0];
				REG_WIDE_COUNT: cfg_q.wide_count       <= cfg_data[CNT_W-1:0];
				REG_TURN_LIMIT: cfg_q.turn_error_limit <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lcs_front #(
		.ROW_WIDTH     (ROW_WIDTH),
		.CENTER_COLUMN (CENTER_COLUMN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat     (beat),
		.pixel    (s_tdata),
		.row_end  (s_tlast),
		.push     (push),
		.push_rec (push_rec)
	);

	lcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (full),
		.pop_valid (pop_valid),
		.pop_rec   (pop_rec),
		.pop       (pop)
	);

	lcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rec_valid (pop_valid),
		.rec       (pop_rec),
		.rec_pop   (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: tb/sv/tb_line_centroid_steering.sv
// Self-checking testbench for the line centroid steering block.
`timescale 1ns / 1ps

module tb_line_centroid_steering;
	import lcs_pkg::*;

	localparam int ROW_W       = 320;
	localparam int CENTER_COL  = 160;
	localparam int SETTLE      = 30;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 7;
	localparam int PHASE_BEATS = 70;

	// One expected steering result.
	typedef struct {
		logic [2:0]        action;
		logic signed [8:0] left;
		logic signed [8:0] right;
		logic [7:0]        thr;
		logic [8:0]        white;
	} steer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_KP_GAIN;
	logic [13:0] cfg_data = '0;

	// Model of the configuration registers.
	int unsigned kp_gain = 90;
	int          base_speed = -50;
	bit          corner_mode = 1'b1;
	int unsigned wide_count = 300;
	int unsigned turn_limit = 150;

	// Model of the row state.
	logic [7:0]  threshold = '0;
	bit          calibrated = 1'b0;
	int          row_max = 0;
	int          row_min = 255;
	int          err_acc = 0;
	int unsigned white_cnt = 0;
	int unsigned col = 0;

	steer_t steer_expect_q[$];
	int     errors = 0;
	int     cycles = 0;
	int     pixels_sent = 0;
	int     rows_sent = 0;
	int     results_seen = 0;
	int     act_seen[5] = '{default: 0};
	bit     quiet = 1'b0;
	int     stall_left = 0;

	line_centroid_steering uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // pixel[7:0]
		.s_tlast  (s_tlast),   // row_end
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // action[2:0], left_drive[11:3], right_drive[20:12],
		                       // threshold_out[28:21], white_seen[37:29]
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("line_centroid_steering verification failed");
			$finish;
		end
	end

	// Receiver stalls in short random bursts, none in the quiet part.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest expected one.
	always @(posedge clk) begin
		steer_t            want;
		logic signed [8:0] got_left;
		logic signed [8:0] got_right;
		if (arst_n && m_tvalid && m_tready) begin
			got_left = m_tdata[11:3];
			got_right = m_tdata[20:12];
			results_seen++;
			if (m_tdata[2:0] <= ACT_CAL)
				act_seen[m_tdata[2:0]]++;
			if (steer_expect_q.size() == 0) begin
				$error("Result beat with no expected result: tdata %h", m_tdata);
				errors++;
			end else begin
				want = steer_expect_q.pop_front();
				if (m_tdata[2:0] !== want.action) begin
					$error("action expected %0d, got %0d", want.action, m_tdata[2:0]);
					errors++;
				end
				if (got_left !== want.left) begin
					$error("left_drive expected %0d, got %0d", want.left, got_left);
					errors++;
				end
				if (got_right !== want.right) begin
					$error("right_drive expected %0d, got %0d", want.right, got_right);
					errors++;
				end
				if (m_tdata[28:21] !== want.thr) begin
					$error("threshold_out expected %0d, got %0d", want.thr,
						m_tdata[28:21]);
					errors++;
				end
				if (m_tdata[37:29] !== want.white) begin
					$error("white_seen expected %0d, got %0d", want.white,
						m_tdata[37:29]);
					errors++;
				end
			end
		end
	end

	function automatic longint clamp_drive(input longint v);
		if (v > 255)
			return 255;
		if (v < -255)
			return -255;
		return v;
	endfunction

	// Advance the row model by one accepted pixel and queue the result of a row end.
	task automatic steer_predict(input logic [7:0] px, input logic last);
		steer_t r;
		longint q;
		longint corr;
		longint b;
		longint lft;
		longint rgt;
		if (!calibrated) begin
			if (px > row_max)
				row_max = px;
			if (px < row_min)
				row_min = px;
		end else if (px > threshold) begin
			err_acc = err_acc + (int'(col) - CENTER_COL);
			if (err_acc > ERR_MAX)
				err_acc = ERR_MAX;
			if (err_acc < ERR_MIN)
				err_acc = ERR_MIN;
			if (white_cnt < 511)
				white_cnt++;
		end
		if (col < ROW_W - 1)
			col++;
		if (last) begin
			if (!calibrated) begin
				threshold = 8'((row_max + row_min) / 2);
				calibrated = 1'b1;
				r.action = ACT_CAL;
				r.left = '0;
				r.right = '0;
				r.white = '0;
			end else begin
				lft = clamp_drive(base_speed);
				rgt = lft;
				if (white_cnt == 0) begin
					r.action = ACT_REVERSE;
				end else if (corner_mode && white_cnt > wide_count &&
						err_acc < -int'(turn_limit)) begin
					r.action = ACT_LEFT;
				end else if (corner_mode && white_cnt > wide_count &&
						err_acc > int'(turn_limit)) begin
					r.action = ACT_RIGHT;
				end else begin
					// Quotient and both drives truncate toward zero.
					q = longint'(err_acc) / longint'(white_cnt);
					corr = longint'(kp_gain) * q;
					b = longint'(base_speed) * 256;
					r.action = ACT_DRIVE;
					lft = clamp_drive((b - corr) / 256);
					rgt = clamp_drive((b + corr) / 256);
				end
				r.left = 9'(lft);
				r.right = 9'(rgt);
				r.white = 9'(white_cnt);
			end
			r.thr = threshold;
			steer_expect_q.push_back(r);
			row_max = 0;
			row_min = 255;
			err_acc = 0;
			white_cnt = 0;
			col = 0;
			rows_sent++;
		end
	endtask

	// Send one pixel beat, with an occasional gap ahead of it.
	task automatic send_pixel(input logic [7:0] px, input logic last);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		steer_predict(px, last);
		pixels_sent++;
	endtask

	// Hold the sender until every expected result is back and the block is quiet.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (steer_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all five registers in one burst of beats; the block must be idle.
	task automatic set_config(input int unsigned kp, input int base, input bit corner,
			input int unsigned wide, input int unsigned limit);
		logic [13:0] vals[5];
		logic [2:0]  idx[5];
		vals = '{14'(kp), {5'b0, 9'(base)}, 14'(corner), 14'(wide), 14'(limit)};
		idx = '{REG_KP_GAIN, REG_BASE_SPEED, REG_CORNER, REG_WIDE_COUNT, REG_TURN_LIMIT};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		kp_gain = kp;
		base_speed = base;
		corner_mode = corner;
		wide_count = wide;
		turn_limit = limit;
	endtask

	// Send a row of the given length; the mode shapes where white pixels fall.
	task automatic send_row(input int len, input int mode);
		logic [7:0] px;
		for (int c = 0; c < len; c++) begin
			case (mode)
				0: px = 8'($urandom_range(0, 255));
				1: px = 8'($urandom_range(0, threshold));
				2: px = 8'($urandom_range(threshold + 1, 255));
				3: px = c[0] ? 8'($urandom_range(threshold + 1, 255))
					: 8'($urandom_range(0, threshold));
				default: px = (c >= CENTER_COL) ? 8'($urandom_range(threshold + 1, 255))
					: 8'($urandom_range(0, threshold));
			endcase
			send_pixel(px, c == len - 1);
		end
	endtask

	// First row after reset sets the threshold to (255 + 0) / 2 = 127.
	task automatic test_calibration();
		send_pixel(8'h80, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'h7F, 1'b1);
	endtask

	// Reset register values: reverse on a dark row, drive on white, one-pixel row.
	task automatic test_reset_settings();
		// A pixel equal to the threshold is not white.
		send_pixel(8'h7F, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'h7F, 1'b1);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h7F, 1'b0);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'hFF, 1'b1);
	endtask

	// A left corner turn and drive saturation at the register extremes.
	task automatic test_turns_and_saturation();
		wait_idle();
		set_config(1023, 255, 1'b1, 0, 0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'hC0, 1'b1);
		send_pixel(8'h00, 1'b1);
		wait_idle();
		set_config(1023, 255, 1'b0, 0, 0);
		send_pixel(8'hFF, 1'b1);
		wait_idle();
		set_config(0, -255, 1'b1, 320, 12880);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h01, 1'b1);
	endtask

	// Random rows over several register settings; the last phase runs without input gaps or receiver stalls.
	task automatic test_random_rows();
		int unsigned kp;
		int          base;
		bit          corner;
		int unsigned wide;
		int unsigned limit;
		int          start;
		int          len;
		int          pick;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			pick = $urandom_range(0, 3);
			kp = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 1023);
			pick = $urandom_range(0, 3);
			base = (pick == 0) ? -255 : (pick == 1) ? 255 : int'($urandom_range(0, 510)) - 255;
			corner = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 3);
			wide = (pick == 0) ? 0 : (pick == 1) ? 320 : $urandom_range(0, 30);
			pick = $urandom_range(0, 3);
			limit = (pick == 0) ? 0 : (pick == 1) ? 12880 : $urandom_range(0, 3000);
			if (ph == 0) begin
				corner = 1'b1;
				wide = 100;
				limit = 500;
			end else if (ph == 1) begin
				corner = 1'b0;
			end
			quiet = (ph == PHASES - 1);
			set_config(kp, base, corner, wide, limit);
			start = pixels_sent;
			// A full row lit on the right half turns right under the first setting.
			if (ph == 0)
				send_row(ROW_W, 4);
			// A long all-white row saturates the count and the error sum.
			if (ph == 1)
				send_row(520, 2);
			while (pixels_sent - start < PHASE_BEATS) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					len = $urandom_range(300, 360);
				else if (pick < 4)
					len = $urandom_range(25, 100);
				else
					len = $urandom_range(1, 24);
				send_row(len, $urandom_range(0, 4));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_calibration();
		test_reset_settings();
		test_turns_and_saturation();
		test_random_rows();
		wait_idle();
		$display("Sent %0d pixels in %0d rows over %0d register settings.",
			pixels_sent, rows_sent, PHASES + 4);
		$display("Checked %0d results: drive %0d, reverse %0d, left %0d, right %0d, cal %0d.",
			results_seen, act_seen[ACT_DRIVE], act_seen[ACT_REVERSE], act_seen[ACT_LEFT],
			act_seen[ACT_RIGHT], act_seen[ACT_CAL]);
		if (errors == 0) begin
			$display("line_centroid_steering verification clean");
		end else begin
			$display("line_centroid_steering verification failed");
		end
		$finish;
	end

endmodule
